// File: rtl/core/mdvd_pkg.sv
package mdvd_pkg;

  typedef enum logic [3:0] {
    PH_VCNT,
    PH_VQUANT,
    PH_VERT,
    PH_EQUANT,
    PH_ETC,
    PH_TCNT,
    PH_TQU,
    PH_TQV,
    PH_TC,
    PH_FCNT,
    PH_FACE,
    PH_FTC
  } phase_t;

  localparam logic [2:0] KIND_VERT = 3'd0;
  localparam logic [2:0] KIND_ETC  = 3'd1;
  localparam logic [2:0] KIND_ITC  = 3'd2;
  localparam logic [2:0] KIND_FACE = 3'd3;
  localparam logic [2:0] KIND_FTC  = 3'd4;
  localparam logic [2:0] KIND_END  = 3'd5;

  localparam int unsigned TEX_EXT_BIT = 0;
  localparam int unsigned TEX_INT_BIT = 1;

  localparam logic [7:0] WORD_MORE = 8'h80;
  localparam logic [7:0] WORD_LOW  = 8'h7f;

  localparam logic [1:0] NCOMP_XYZ = 2'd3;
  localparam logic [1:0] NCOMP_UV  = 2'd2;

  typedef logic [1:0]  tex_flags_t;
  typedef logic [7:0]  stream_byte_t;
  typedef logic [14:0] word_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         axis;
    logic signed [31:0] value;
    logic [15:0]        quantizer;
    logic [15:0]        element_index;
    logic               last;
  } result_t;

endpackage

// File: rtl/core/mdvd_ifs.sv
interface mdvd_byte_if;
  import mdvd_pkg::*;

  logic         valid;
  logic         ready;
  stream_byte_t stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface mdvd_result_if;
  import mdvd_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [1:0]         axis;
  logic signed [31:0] value;
  logic [15:0]        quantizer;
  logic [15:0]        element_index;
  logic               last;

  modport source (
    output valid, output kind, output axis, output value, output quantizer,
    output element_index, output last, input ready
  );
  modport sink (
    input valid, input kind, input axis, input value, input quantizer,
    input element_index, input last, output ready
  );
endinterface

// File: rtl/core/mesh_delta_varint_decoder.sv
// Submesh body decoder: one raw byte per input transaction on in_chan,
// at most one decoded value per byte on out_chan.
// Bytes are taken into an input register; from there the decode step
// updates counts, quantizers, per-axis accumulators and the face
// high-water mark, and loads the result register when a word completes.
// A result passes through the input register and then the result register.
// Throughput is one byte per cycle while out_chan is ready; the pair of
// registers lets a new byte in while a finished result waits.
// Header bytes and the first byte of two-byte words produce no result.
// A zero face count produces one empty-end result with last set.
// cfg_we/cfg_wdata write texture_flags; write only while no transaction is
// in flight. The flags are looked at when each section ends and on each face word.
// Reset (rst_n low, synchronous) clears all decode state, the flags and
// both valid bits; the block then expects a vertex count.
// When out_chan stalls, the held result stays put, one more byte may sit
// in the input register, and in_chan.ready drops until the result leaves.
// Accumulators wrap at ACCUMULATOR_WIDTH bits; values are sign extended
// or truncated to 32 bits.
module mesh_delta_varint_decoder #(
  parameter int unsigned ACCUMULATOR_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mdvd_byte_if.sink             in_chan,
  mdvd_result_if.source         out_chan,
  input  logic                  cfg_we,
  input  mdvd_pkg::tex_flags_t  cfg_wdata
);
  import mdvd_pkg::*;

  localparam int unsigned AW = ACCUMULATOR_WIDTH;

  tex_flags_t   tex_r;
  stream_byte_t sbyte_r;
  logic         sbyte_vld_r;
  logic         out_vld_r;
  result_t      out_res_r;

  phase_t       phase_r, phase_nxt;
  stream_byte_t pend_byte_r, pend_byte_nxt;
  logic         pend_vld_r, pend_vld_nxt;
  logic [15:0]  vtot_r, vtot_nxt;
  logic [15:0]  ttot_r, ttot_nxt;
  logic [15:0]  ftot_r, ftot_nxt;
  logic [15:0]  item_r, item_nxt;
  logic [1:0]   axis_r, axis_nxt;
  logic [15:0]  quant_vert_r, quant_vert_nxt;
  logic [15:0]  quant_ext_r, quant_ext_nxt;
  logic [15:0]  quant_u_r, quant_u_nxt;
  logic [15:0]  quant_v_r, quant_v_nxt;
  logic [AW-1:0] acc_r [3];
  logic [AW-1:0] acc_nxt [3];
  logic [31:0]  hw_r, hw_nxt;

  logic         stage_go;
  logic         res_vld;
  result_t      res;

  logic [15:0]  v16;
  logic         wd_done;
  word_t        word_w;
  logic [AW-1:0] delta;
  logic [AW-1:0] acc_sum;
  logic signed [63:0] acc_ext;
  logic [31:0]  face_val;
  logic [1:0]   axis_inc;
  logic [15:0]  item_inc;
  logic [1:0]   ncomp;
  logic [15:0]  total;
  logic         axis_wrap;
  logic         sect_done;
  phase_t       ph_after_ext;
  phase_t       ph_after_vert;
  logic         go_enter;
  phase_t       enter_ph;

  assign stage_go       = sbyte_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready  = !sbyte_vld_r || stage_go;

  assign out_chan.valid         = out_vld_r;
  assign out_chan.kind          = out_res_r.kind;
  assign out_chan.axis          = out_res_r.axis;
  assign out_chan.value         = out_res_r.value;
  assign out_chan.quantizer     = out_res_r.quantizer;
  assign out_chan.element_index = out_res_r.element_index;
  assign out_chan.last          = out_res_r.last;

  // word assembly
  assign v16     = {sbyte_r, pend_byte_r};
  assign wd_done = pend_vld_r || ((sbyte_r & WORD_MORE) == 8'h00);
  assign word_w  = pend_vld_r ? {sbyte_r, pend_byte_r[6:0]} : {7'h00, sbyte_r};

  // zigzag delta and accumulation on the current axis
  assign delta    = AW'(word_w[14:1]) ^ {AW{word_w[0]}};
  assign acc_sum  = acc_r[axis_r] + delta;
  assign acc_ext  = 64'(signed'(acc_sum));
  assign face_val = hw_r - 32'(word_w);

  assign axis_inc  = axis_r + 2'd1;
  assign item_inc  = item_r + 16'd1;
  assign axis_wrap = axis_inc >= ncomp;
  assign sect_done = axis_wrap && (item_inc >= total);

  assign ph_after_ext  = tex_r[TEX_INT_BIT] ? PH_TCNT : PH_FCNT;
  assign ph_after_vert = tex_r[TEX_EXT_BIT] ? PH_EQUANT : ph_after_ext;

  always_comb begin
    case (phase_r)
      PH_VERT, PH_ETC: begin
        ncomp = (phase_r == PH_VERT) ? NCOMP_XYZ : NCOMP_UV;
        total = vtot_r;
      end
      PH_TC: begin
        ncomp = NCOMP_UV;
        total = ttot_r;
      end
      default: begin
        ncomp = NCOMP_XYZ;
        total = ftot_r;
      end
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    pend_byte_nxt  = pend_byte_r;
    pend_vld_nxt   = pend_vld_r;
    vtot_nxt       = vtot_r;
    ttot_nxt       = ttot_r;
    ftot_nxt       = ftot_r;
    item_nxt       = item_r;
    axis_nxt       = axis_r;
    quant_vert_nxt = quant_vert_r;
    quant_ext_nxt  = quant_ext_r;
    quant_u_nxt    = quant_u_r;
    quant_v_nxt    = quant_v_r;
    acc_nxt        = acc_r;
    hw_nxt         = hw_r;
    go_enter       = 1'b0;
    enter_ph       = PH_VCNT;
    res_vld        = 1'b0;
    res            = '0;

    case (phase_r)
      PH_VCNT, PH_VQUANT, PH_EQUANT, PH_TCNT, PH_TQU, PH_TQV, PH_FCNT: begin
        pend_vld_nxt = !pend_vld_r;
        if (!pend_vld_r) begin
          pend_byte_nxt = sbyte_r;
        end else begin
          case (phase_r)
            PH_VCNT: begin
              vtot_nxt  = v16;
              phase_nxt = PH_VQUANT;
            end
            PH_VQUANT: begin
              quant_vert_nxt = v16;
              go_enter       = 1'b1;
              enter_ph       = (vtot_r != 16'd0) ? PH_VERT : ph_after_vert;
            end
            PH_EQUANT: begin
              quant_ext_nxt = v16;
              go_enter      = 1'b1;
              enter_ph      = (vtot_r != 16'd0) ? PH_ETC : ph_after_ext;
            end
            PH_TCNT: begin
              ttot_nxt  = v16;
              phase_nxt = PH_TQU;
            end
            PH_TQU: begin
              quant_u_nxt = v16;
              phase_nxt   = PH_TQV;
            end
            PH_TQV: begin
              quant_v_nxt = v16;
              go_enter    = 1'b1;
              enter_ph    = (ttot_r != 16'd0) ? PH_TC : PH_FCNT;
            end
            default: begin
              ftot_nxt = v16;
              go_enter = 1'b1;
              if (v16 != 16'd0) begin
                enter_ph = PH_FACE;
              end else begin
                enter_ph  = PH_VCNT;
                res_vld   = 1'b1;
                res.kind  = KIND_END;
                res.last  = 1'b1;
              end
            end
          endcase
        end
      end

      PH_VERT, PH_ETC, PH_TC, PH_FACE, PH_FTC: begin
        pend_vld_nxt = !pend_vld_r && ((sbyte_r & WORD_MORE) != 8'h00);
        if (!pend_vld_r) begin
          pend_byte_nxt = sbyte_r;
        end
        if (wd_done) begin
          res_vld           = 1'b1;
          res.axis          = axis_r;
          res.element_index = item_r;
          if (axis_wrap) begin
            axis_nxt = 2'd0;
            item_nxt = item_inc;
          end else begin
            axis_nxt = axis_inc;
          end
          case (phase_r)
            PH_VERT, PH_ETC, PH_TC: begin
              acc_nxt[axis_r] = acc_sum;
              res.value       = acc_ext[31:0];
              case (phase_r)
                PH_VERT: begin
                  res.kind      = KIND_VERT;
                  res.quantizer = quant_vert_r;
                  enter_ph      = ph_after_vert;
                end
                PH_ETC: begin
                  res.kind      = KIND_ETC;
                  res.quantizer = quant_ext_r;
                  enter_ph      = ph_after_ext;
                end
                default: begin
                  res.kind      = KIND_ITC;
                  res.quantizer = axis_r[0] ? quant_v_r : quant_u_r;
                  enter_ph      = PH_FCNT;
                end
              endcase
              go_enter = sect_done;
            end
            default: begin
              res.value = face_val;
              if (word_w == '0) begin
                hw_nxt = hw_r + 32'd1;
              end
              go_enter = sect_done;
              if (phase_r == PH_FACE) begin
                res.kind = KIND_FACE;
                if (tex_r[TEX_INT_BIT]) begin
                  enter_ph = PH_FTC;
                end else begin
                  enter_ph = PH_VCNT;
                  res.last = sect_done;
                end
              end else begin
                res.kind = KIND_FTC;
                enter_ph = PH_VCNT;
                res.last = sect_done;
              end
            end
          endcase
        end
      end

      default: begin
        pend_vld_nxt = 1'b0;
        go_enter     = 1'b1;
        enter_ph     = PH_VCNT;
      end
    endcase

    if (go_enter) begin
      phase_nxt = enter_ph;
      item_nxt  = '0;
      axis_nxt  = '0;
      acc_nxt   = '{default: '0};
      hw_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_r        <= '0;
      sbyte_vld_r  <= 1'b0;
      out_vld_r    <= 1'b0;
      phase_r      <= PH_VCNT;
      pend_byte_r  <= '0;
      pend_vld_r   <= 1'b0;
      vtot_r       <= '0;
      ttot_r       <= '0;
      ftot_r       <= '0;
      item_r       <= '0;
      axis_r       <= '0;
      quant_vert_r <= '0;
      quant_ext_r  <= '0;
      quant_u_r    <= '0;
      quant_v_r    <= '0;
      acc_r        <= '{default: '0};
      hw_r         <= '0;
    end else begin
      if (cfg_we) begin
        tex_r <= cfg_wdata;
      end
      if (in_chan.valid && in_chan.ready) begin
        sbyte_vld_r <= 1'b1;
      end else if (stage_go) begin
        sbyte_vld_r <= 1'b0;
      end
      if (stage_go) begin
        out_vld_r <= res_vld;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      if (stage_go) begin
        phase_r      <= phase_nxt;
        pend_byte_r  <= pend_byte_nxt;
        pend_vld_r   <= pend_vld_nxt;
        vtot_r       <= vtot_nxt;
        ttot_r       <= ttot_nxt;
        ftot_r       <= ftot_nxt;
        item_r       <= item_nxt;
        axis_r       <= axis_nxt;
        quant_vert_r <= quant_vert_nxt;
        quant_ext_r  <= quant_ext_nxt;
        quant_u_r    <= quant_u_nxt;
        quant_v_r    <= quant_v_nxt;
        acc_r        <= acc_nxt;
        hw_r         <= hw_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      sbyte_r <= in_chan.stream_byte;
    end
    if (stage_go && res_vld) begin
      out_res_r <= res;
    end
  end

endmodule

// File: rtl/core/mdvd_checker.sv
module mdvd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_kind,
  input logic signed [31:0] out_value,
  input logic [15:0]        out_quantizer,
  input logic               out_last
);
  import mdvd_pkg::*;

  logic out_face_kind;
  assign out_face_kind = (out_kind == KIND_FACE) || (out_kind == KIND_FTC) ||
                         (out_kind == KIND_END);

  // a held result does not vanish
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_kind))
    else $error("result changed while stalled");

  // nothing comes out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_face_quant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_face_kind |-> out_quantizer == 16'd0)
    else $error("face result carries a quantizer");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_last || out_kind == KIND_END) |->
      out_face_kind && (out_last || out_kind != KIND_END))
    else $error("last flag on a wrong kind");

endmodule

bind mesh_delta_varint_decoder mdvd_checker u_mdvd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_kind      (out_chan.kind),
  .out_value     (out_chan.value),
  .out_quantizer (out_chan.quantizer),
  .out_last      (out_chan.last)
);
